// ===== hdl/bmst_pkg.sv =====
package bmst_pkg;

    localparam int C_MAX_VERTICES = 64;
    localparam int C_MAX_EDGES    = 1024;
    localparam int C_WEIGHT_BITS  = 32;

    localparam int C_VTX_BITS   = 6;
    localparam int C_WORD_BITS  = 32;
    localparam int C_TOTAL_BITS = 38;
    localparam int C_CFG_BITS   = 7;
    localparam int C_RANK_BITS  = 3;

    localparam logic [C_CFG_BITS-1:0] C_VC_RESET = 7'd64;

    typedef struct packed {
        logic [C_VTX_BITS-1:0]   tree_u;
        logic [C_VTX_BITS-1:0]   tree_v;
        logic [C_WORD_BITS-1:0]  tree_weight;
        logic [C_TOTAL_BITS-1:0] running_total;
        logic                    edge_present;
        logic                    connected;
        logic                    edges_dropped;
        logic                    last_out;
    } t_res;

endpackage

// ===== hdl/bmst_ram.sv =====
module bmst_ram #(
    parameter int W = 8,
    parameter int D = 2,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hdl/bmst_core.sv =====
module bmst_core #(
    parameter int MAX_VERTICES = bmst_pkg::C_MAX_VERTICES,
    parameter int MAX_EDGES    = bmst_pkg::C_MAX_EDGES,
    parameter int WEIGHT_BITS  = bmst_pkg::C_WEIGHT_BITS,
    localparam int VW  = $clog2(MAX_VERTICES),
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
    localparam int EW  = 2 * bmst_pkg::C_VTX_BITS + WEIGHT_BITS,
    localparam int PW  = VW + bmst_pkg::C_RANK_BITS,
    localparam int BW  = EAW + WEIGHT_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bmst_pkg::C_CFG_BITS-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [bmst_pkg::C_VTX_BITS-1:0]    i_end_u,
    input  logic [bmst_pkg::C_VTX_BITS-1:0]    i_end_v,
    input  logic [bmst_pkg::C_WORD_BITS-1:0]   i_edge_weight,
    input  logic                               i_final_edge,
    input  logic                               i_slot_free,
    output logic                               o_push,
    output bmst_pkg::t_res                     o_res,
    output logic                               o_e_we,
    output logic [EAW-1:0]                     o_e_waddr,
    output logic [EW-1:0]                      o_e_wdata,
    output logic [EAW-1:0]                     o_e_raddr,
    input  logic [EW-1:0]                      i_e_rdata,
    output logic                               o_p_we,
    output logic [VW-1:0]                      o_p_waddr,
    output logic [PW-1:0]                      o_p_wdata,
    output logic [VW-1:0]                      o_p_raddr,
    input  logic [PW-1:0]                      i_p_rdata,
    output logic                               o_b_we,
    output logic [VW-1:0]                      o_b_waddr,
    output logic [BW-1:0]                      o_b_wdata,
    output logic [VW-1:0]                      o_b_raddr,
    input  logic [BW-1:0]                      i_b_rdata
);
    import bmst_pkg::*;

    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int ETW = $clog2(MAX_EDGES + 1);
    localparam int RW  = C_RANK_BITS;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_INIT    = 5'd1;
    localparam logic [4:0] S_RND     = 5'd2;
    localparam logic [4:0] S_SC_RD   = 5'd3;
    localparam logic [4:0] S_SC_E    = 5'd4;
    localparam logic [4:0] S_SC_CV   = 5'd5;
    localparam logic [4:0] S_SC_CMP  = 5'd6;
    localparam logic [4:0] S_BU_RD   = 5'd7;
    localparam logic [4:0] S_BU_CHK  = 5'd8;
    localparam logic [4:0] S_BV_RD   = 5'd9;
    localparam logic [4:0] S_BV_CHK  = 5'd10;
    localparam logic [4:0] S_AD_I    = 5'd11;
    localparam logic [4:0] S_AD_B    = 5'd12;
    localparam logic [4:0] S_AD_E    = 5'd13;
    localparam logic [4:0] S_AD_PU   = 5'd14;
    localparam logic [4:0] S_AD_PV   = 5'd15;
    localparam logic [4:0] S_LINK2   = 5'd16;
    localparam logic [4:0] S_PUSH    = 5'd17;
    localparam logic [4:0] S_FIN     = 5'd18;
    localparam logic [4:0] S_FIND_RD = 5'd19;
    localparam logic [4:0] S_FIND_CK = 5'd20;

    logic [4:0]              r_state, n_state;
    logic [4:0]              r_ret, n_ret;
    logic [C_CFG_BITS-1:0]   r_cfg, n_cfg;
    logic [ETW-1:0]          r_etot, n_etot;
    logic                    r_ovf, n_ovf;
    logic [VCW-1:0]          r_vc, n_vc;
    logic [VCW-1:0]          r_comp, n_comp;
    logic [C_TOTAL_BITS-1:0] r_sum, n_sum;
    logic [ETW-1:0]          r_ei, n_ei;
    logic [VCW-1:0]          r_ai, n_ai;
    logic [MAX_VERTICES-1:0] r_bval, n_bval;
    logic                    r_added, n_added;
    logic [EW-1:0]           r_e, n_e;
    logic [VW-1:0]           r_fx, n_fx;
    logic [VW-1:0]           r_froot, n_froot;
    logic [RW-1:0]           r_frank, n_frank;
    logic [VW-1:0]           r_cu, n_cu;
    logic [VW-1:0]           r_cv, n_cv;
    logic [RW-1:0]           r_rku, n_rku;
    logic                    r_eq, n_eq;
    logic                    r_have, n_have;
    t_res                    r_pend, n_pend;

    logic [C_VTX_BITS-1:0]   e_u, e_v;
    logic [WEIGHT_BITS-1:0]  e_w;
    logic [VW-1:0]           p_par;
    logic [RW-1:0]           p_rank;
    logic [EAW-1:0]          b_idx;
    logic [WEIGHT_BITS-1:0]  b_w;
    logic                    in_acc;
    t_res                    cur;

    assign e_u    = r_e[C_VTX_BITS-1:0];
    assign e_v    = r_e[2*C_VTX_BITS-1:C_VTX_BITS];
    assign e_w    = r_e[EW-1:2*C_VTX_BITS];
    assign p_par  = i_p_rdata[VW-1:0];
    assign p_rank = i_p_rdata[PW-1:VW];
    assign b_idx  = i_b_rdata[EAW-1:0];
    assign b_w    = i_b_rdata[BW-1:EAW];

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign o_e_we    = in_acc && (r_etot != ETW'(MAX_EDGES));
    assign o_e_waddr = r_etot[EAW-1:0];
    assign o_e_wdata = {WEIGHT_BITS'(i_edge_weight), i_end_v, i_end_u};
    assign o_e_raddr = (r_state == S_AD_B) ? b_idx : r_ei[EAW-1:0];

    assign o_p_raddr = (r_state == S_FIND_CK) ? p_par : r_fx;
    assign o_b_raddr = (r_state == S_BV_RD) ? r_cv :
                       (r_state == S_AD_I) ? r_ai[VW-1:0] : r_cu;

    always_comb begin
        cur               = '0;
        cur.tree_u        = e_u;
        cur.tree_v        = e_v;
        cur.tree_weight   = C_WORD_BITS'(e_w);
        cur.running_total = r_sum;
        cur.edge_present  = 1'b1;
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_cfg   = r_cfg;
        n_etot  = r_etot;
        n_ovf   = r_ovf;
        n_vc    = r_vc;
        n_comp  = r_comp;
        n_sum   = r_sum;
        n_ei    = r_ei;
        n_ai    = r_ai;
        n_bval  = r_bval;
        n_added = r_added;
        n_e     = r_e;
        n_fx    = r_fx;
        n_froot = r_froot;
        n_frank = r_frank;
        n_cu    = r_cu;
        n_cv    = r_cv;
        n_rku   = r_rku;
        n_eq    = r_eq;
        n_have  = r_have;
        n_pend  = r_pend;
        o_p_we    = 1'b0;
        o_p_waddr = r_ai[VW-1:0];
        o_p_wdata = {RW'(0), r_ai[VW-1:0]};
        o_b_we    = 1'b0;
        o_b_waddr = r_cu;
        o_b_wdata = {e_w, r_ei[EAW-1:0]};
        o_push    = 1'b0;
        o_res     = r_pend;

        if (i_cfg_we) begin
            n_cfg = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_etot == ETW'(MAX_EDGES)) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_etot = r_etot + ETW'(1);
                    end
                    if (i_final_edge) begin
                        n_ai = '0;
                        if (r_cfg == '0) begin
                            n_vc = VCW'(1);
                        end else if (r_cfg > C_CFG_BITS'(MAX_VERTICES)) begin
                            n_vc = VCW'(MAX_VERTICES);
                        end else begin
                            n_vc = VCW'(r_cfg);
                        end
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_p_we = 1'b1;
                n_ai   = r_ai + VCW'(1);
                if (r_ai == VCW'(MAX_VERTICES - 1)) begin
                    n_comp  = r_vc;
                    n_sum   = '0;
                    n_have  = 1'b0;
                    n_state = S_RND;
                end
            end
            S_RND: begin
                if (r_comp <= VCW'(1)) begin
                    n_state = S_FIN;
                end else begin
                    n_bval  = '0;
                    n_added = 1'b0;
                    n_ei    = '0;
                    n_state = S_SC_RD;
                end
            end
            S_SC_RD: begin
                if (r_ei >= r_etot) begin
                    n_ai    = '0;
                    n_state = S_AD_I;
                end else begin
                    n_state = S_SC_E;
                end
            end
            S_SC_E: begin
                n_e = i_e_rdata;
                if (C_CFG_BITS'(i_e_rdata[C_VTX_BITS-1:0]) >= C_CFG_BITS'(r_vc) ||
                    C_CFG_BITS'(i_e_rdata[2*C_VTX_BITS-1:C_VTX_BITS])
                        >= C_CFG_BITS'(r_vc)) begin
                    n_ei    = r_ei + ETW'(1);
                    n_state = S_SC_RD;
                end else begin
                    n_fx    = i_e_rdata[VW-1:0];
                    n_ret   = S_SC_CV;
                    n_state = S_FIND_RD;
                end
            end
            S_SC_CV: begin
                n_cu    = r_froot;
                n_fx    = e_v[VW-1:0];
                n_ret   = S_SC_CMP;
                n_state = S_FIND_RD;
            end
            S_SC_CMP: begin
                n_cv = r_froot;
                if (r_froot == r_cu) begin
                    n_ei    = r_ei + ETW'(1);
                    n_state = S_SC_RD;
                end else begin
                    n_state = S_BU_RD;
                end
            end
            S_BU_RD: begin
                n_state = S_BU_CHK;
            end
            S_BU_CHK: begin
                if (!r_bval[r_cu] || e_w < b_w) begin
                    o_b_we        = 1'b1;
                    o_b_waddr     = r_cu;
                    n_bval[r_cu]  = 1'b1;
                end
                n_state = S_BV_RD;
            end
            S_BV_RD: begin
                n_state = S_BV_CHK;
            end
            S_BV_CHK: begin
                if (!r_bval[r_cv] || e_w < b_w) begin
                    o_b_we        = 1'b1;
                    o_b_waddr     = r_cv;
                    n_bval[r_cv]  = 1'b1;
                end
                n_ei    = r_ei + ETW'(1);
                n_state = S_SC_RD;
            end
            S_AD_I: begin
                if (r_ai >= r_vc) begin
                    n_state = r_added ? S_RND : S_FIN;
                end else if (!r_bval[r_ai[VW-1:0]]) begin
                    n_ai = r_ai + VCW'(1);
                end else begin
                    n_state = S_AD_B;
                end
            end
            S_AD_B: begin
                n_state = S_AD_E;
            end
            S_AD_E: begin
                n_e     = i_e_rdata;
                n_fx    = i_e_rdata[VW-1:0];
                n_ret   = S_AD_PU;
                n_state = S_FIND_RD;
            end
            S_AD_PU: begin
                n_cu    = r_froot;
                n_rku   = r_frank;
                n_fx    = e_v[VW-1:0];
                n_ret   = S_AD_PV;
                n_state = S_FIND_RD;
            end
            S_AD_PV: begin
                if (r_froot == r_cu) begin
                    n_ai    = r_ai + VCW'(1);
                    n_state = S_AD_I;
                end else begin
                    o_p_we = 1'b1;
                    n_eq   = (r_rku == r_frank);
                    if (r_rku < r_frank) begin
                        o_p_waddr = r_cu;
                        o_p_wdata = {r_rku, r_froot};
                        n_cu      = r_froot;
                        n_cv      = r_cu;
                        n_rku     = r_frank;
                    end else begin
                        o_p_waddr = r_froot;
                        o_p_wdata = {r_frank, r_cu};
                        n_cv      = r_froot;
                    end
                    n_state = S_LINK2;
                end
            end
            S_LINK2: begin
                if (r_eq) begin
                    o_p_we    = 1'b1;
                    o_p_waddr = r_cu;
                    o_p_wdata = {r_rku + RW'(1), r_cu};
                end
                n_sum   = r_sum + C_TOTAL_BITS'(e_w);
                n_comp  = r_comp - VCW'(1);
                n_added = 1'b1;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (!r_have || i_slot_free) begin
                    o_push  = r_have;
                    n_pend  = cur;
                    n_have  = 1'b1;
                    n_ai    = r_ai + VCW'(1);
                    n_state = S_AD_I;
                end
            end
            S_FIN: begin
                if (i_slot_free) begin
                    o_push = 1'b1;
                    if (!r_have) begin
                        o_res = '0;
                    end
                    o_res.connected     = (r_comp == VCW'(1));
                    o_res.edges_dropped = r_ovf;
                    o_res.last_out      = 1'b1;
                    n_have  = 1'b0;
                    n_etot  = '0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_FIND_RD: begin
                n_state = S_FIND_CK;
            end
            S_FIND_CK: begin
                if (p_par == r_fx) begin
                    n_froot = r_fx;
                    n_frank = p_rank;
                    n_state = r_ret;
                end else begin
                    n_fx = p_par;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg   <= C_VC_RESET;
            r_etot  <= '0;
            r_ovf   <= 1'b0;
            r_have  <= 1'b0;
            r_bval  <= '0;
            r_added <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cfg   <= n_cfg;
            r_etot  <= n_etot;
            r_ovf   <= n_ovf;
            r_have  <= n_have;
            r_bval  <= n_bval;
            r_added <= n_added;
        end
        r_ret   <= n_ret;
        r_vc    <= n_vc;
        r_comp  <= n_comp;
        r_sum   <= n_sum;
        r_ei    <= n_ei;
        r_ai    <= n_ai;
        r_e     <= n_e;
        r_fx    <= n_fx;
        r_froot <= n_froot;
        r_frank <= n_frank;
        r_cu    <= n_cu;
        r_cv    <= n_cv;
        r_rku   <= n_rku;
        r_eq    <= n_eq;
        r_pend  <= n_pend;
    end

endmodule

// ===== hdl/boruvka_mst.sv =====
// Minimum spanning tree engine (Boruvka rounds over a union-find table).
// Input channel: one edge word per accepted cycle (i_in_valid high,
// o_in_stall low) is written to the edge memory if it has room, else it is
// dropped and edges_dropped is set, so loading runs at one edge per cycle.
// The word with i_final_edge set also starts the run; o_in_stall stays high
// until the run's last result is loaded into the output register.
// Run: a table init, then per round one pass over the edges (an edge with
// an end out of range is skipped, the others take two finds each) plus an
// adoption pass over the vertices (a vertex without a best edge is skipped).
// At most log2(vertex count) rounds adopt edges; a disconnected graph ends
// with one more that adopts none.
// Output channel: one word per adopted tree edge, in adoption order, then
// last_out on the final word together with connected and edges_dropped.
// An empty tree gives one word with edge_present low. Results go through
// an output register; while it is full and i_out_stall is high it holds
// and the engine waits. The user must write i_cfg_data only while idle;
// the block does not enforce it. It is read at run start. Reset (synchronous)
// empties the edge list, clears the flags and loads a vertex count of 64.
module boruvka_mst #(
    parameter int MAX_VERTICES = bmst_pkg::C_MAX_VERTICES,
    parameter int MAX_EDGES    = bmst_pkg::C_MAX_EDGES,
    parameter int WEIGHT_BITS  = bmst_pkg::C_WEIGHT_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bmst_pkg::C_CFG_BITS-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [bmst_pkg::C_VTX_BITS-1:0]  i_end_u,
    input  logic [bmst_pkg::C_VTX_BITS-1:0]  i_end_v,
    input  logic [bmst_pkg::C_WORD_BITS-1:0] i_edge_weight,
    input  logic                             i_final_edge,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [bmst_pkg::C_VTX_BITS-1:0]  o_tree_u,
    output logic [bmst_pkg::C_VTX_BITS-1:0]  o_tree_v,
    output logic [bmst_pkg::C_WORD_BITS-1:0] o_tree_weight,
    output logic [bmst_pkg::C_TOTAL_BITS-1:0] o_running_total,
    output logic                             o_edge_present,
    output logic                             o_connected,
    output logic                             o_edges_dropped,
    output logic                             o_last_out
);
    import bmst_pkg::*;

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EW  = 2 * C_VTX_BITS + WEIGHT_BITS;
    localparam int PW  = VW + C_RANK_BITS;
    localparam int BW  = EAW + WEIGHT_BITS;

    logic           e_we, p_we, b_we;
    logic [EAW-1:0] e_waddr, e_raddr;
    logic [EW-1:0]  e_wdata, e_rdata;
    logic [VW-1:0]  p_waddr, p_raddr, b_waddr, b_raddr;
    logic [PW-1:0]  p_wdata, p_rdata;
    logic [BW-1:0]  b_wdata, b_rdata;
    logic           push, slot_free;
    t_res           res;
    logic           r_ovalid;
    t_res           r_out;

    assign slot_free = !r_ovalid || !i_out_stall;

    bmst_core #(
        .MAX_VERTICES(MAX_VERTICES),
        .MAX_EDGES(MAX_EDGES),
        .WEIGHT_BITS(WEIGHT_BITS)
    ) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_end_u(i_end_u), .i_end_v(i_end_v),
        .i_edge_weight(i_edge_weight), .i_final_edge(i_final_edge),
        .i_slot_free(slot_free), .o_push(push), .o_res(res),
        .o_e_we(e_we), .o_e_waddr(e_waddr), .o_e_wdata(e_wdata),
        .o_e_raddr(e_raddr), .i_e_rdata(e_rdata),
        .o_p_we(p_we), .o_p_waddr(p_waddr), .o_p_wdata(p_wdata),
        .o_p_raddr(p_raddr), .i_p_rdata(p_rdata),
        .o_b_we(b_we), .o_b_waddr(b_waddr), .o_b_wdata(b_wdata),
        .o_b_raddr(b_raddr), .i_b_rdata(b_rdata)
    );

    bmst_ram #(.W(EW), .D(MAX_EDGES)) u_edge_ram (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_raddr(e_raddr), .o_rdata(e_rdata)
    );

    bmst_ram #(.W(PW), .D(MAX_VERTICES)) u_parent_ram (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(p_raddr), .o_rdata(p_rdata)
    );

    bmst_ram #(.W(BW), .D(MAX_VERTICES)) u_best_ram (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_waddr), .i_wdata(b_wdata),
        .i_raddr(b_raddr), .o_rdata(b_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (push) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
        if (push) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_tree_u        = r_out.tree_u;
    assign o_tree_v        = r_out.tree_v;
    assign o_tree_weight   = r_out.tree_weight;
    assign o_running_total = r_out.running_total;
    assign o_edge_present  = r_out.edge_present;
    assign o_connected     = r_out.connected;
    assign o_edges_dropped = r_out.edges_dropped;
    assign o_last_out      = r_out.last_out;

endmodule

// ===== hdl/bmst_checker.sv =====
module bmst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [37:0] o_running_total,
    input logic        o_edge_present,
    input logic        o_connected,
    input logic        o_edges_dropped,
    input logic        o_last_out
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_running_total))
        else $error("stalled result changed");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_out |-> !o_connected && !o_edges_dropped)
        else $error("run flags on a non-final result");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_edge_present |-> o_last_out && o_running_total == 38'd0)
        else $error("bad empty-tree result");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("not idle after reset");

endmodule

bind boruvka_mst bmst_checker u_bmst_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_in_stall(o_in_stall),
    .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
    .o_running_total(o_running_total), .o_edge_present(o_edge_present),
    .o_connected(o_connected), .o_edges_dropped(o_edges_dropped),
    .o_last_out(o_last_out)
);
